@@ rtl/core/assert_macros.svh @@
// Assertion helpers for the checker file sha512t_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/sha512t_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package sha512t_pkg;

    localparam int WordW = 64;
    localparam int BlockWords = 16;
    localparam int Rounds = 80;
    localparam int WIdxW = $clog2(BlockWords);
    localparam int RndW = $clog2(Rounds);

    // Datapath commands
    typedef struct packed {
        logic       load_word;   // write wr_word into the block buffer
        logic [1:0] word_sel;    // which word to write
        logic       start_comp;  // begin 80-round compression
        logic       reset_state; // restore initial chaining state
        logic       round_step;  // run one round
        logic       finish_comp; // add working vars into chaining state
    } t_dp_cmd;

    localparam logic [1:0] SelMsg  = 2'd0;
    localparam logic [1:0] SelPad  = 2'd1;
    localparam logic [1:0] SelZero = 2'd2;
    localparam logic [1:0] SelLen  = 2'd3;

    localparam logic [WordW-1:0] IV [8] = '{
        64'h22312194fc2bf72c, 64'h9f555fa3c84c64c2,
        64'h2393b86b6f53b151, 64'h963877195940eabd,
        64'h96283ee2a88effe3, 64'hbe5e1e2553863992,
        64'h2b0199fc2c85b8aa, 64'h0eb72ddc81c52ca2
    };

    localparam logic [WordW-1:0] KTab [Rounds] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int n);
        rotr = (x >> n) | (x << (WordW - n));
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/sha512t_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sha512t_datapath (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire sha512t_pkg::t_dp_cmd   i_cmd,
    input  wire [63:0]                  i_word,
    input  wire [3:0]                   i_vb,
    input  wire                         i_last,
    input  wire                         i_count_en,
    output logic [255:0]                o_digest
);
    localparam int W = sha512t_pkg::WordW;

    logic [W-1:0] r_h [8];
    logic [W-1:0] r_v [8];
    logic [W-1:0] r_w [16];      // message schedule window, also the block buffer
    logic [sha512t_pkg::RndW-1:0] r_rnd;
    logic [W-1:0] r_cnt;

    logic [3:0]   vb_sat;
    logic [W-1:0] mask, msg_word, wr_word, sched_new, t1, t2, e, a;
    logic [W-1:0] n_cnt;

    assign vb_sat = (i_vb > 4'd8) ? 4'd8 : i_vb;

    // keep the used top bytes, put the 0x80 marker right after them (none when full)
    assign mask = ~(64'hffff_ffff_ffff_ffff >> {vb_sat, 3'b000});
    assign msg_word = i_last
        ? ((i_word & mask) | (64'h8000_0000_0000_0000 >> {vb_sat, 3'b000}))
        : i_word;

    always_comb begin
        case (i_cmd.word_sel)
            sha512t_pkg::SelMsg:  wr_word = msg_word;
            sha512t_pkg::SelPad:  wr_word = 64'h8000_0000_0000_0000;
            sha512t_pkg::SelZero: wr_word = '0;
            default:              wr_word = {r_cnt[W-4:0], 3'b000};
        endcase
    end

    assign sched_new = r_w[0] + r_w[9]
        + (sha512t_pkg::rotr(r_w[1], 1) ^ sha512t_pkg::rotr(r_w[1], 8) ^ (r_w[1] >> 7))
        + (sha512t_pkg::rotr(r_w[14], 19) ^ sha512t_pkg::rotr(r_w[14], 61) ^ (r_w[14] >> 6));

    assign e = r_v[4];
    assign a = r_v[0];
    assign t1 = r_v[7] + (sha512t_pkg::rotr(e, 14) ^ sha512t_pkg::rotr(e, 18)
              ^ sha512t_pkg::rotr(e, 41)) + (r_v[6] ^ (e & (r_v[5] ^ r_v[6])))
              + sha512t_pkg::KTab[r_rnd] + r_w[0];
    assign t2 = (sha512t_pkg::rotr(a, 28) ^ sha512t_pkg::rotr(a, 34) ^ sha512t_pkg::rotr(a, 39))
              + ((a & r_v[1]) | (r_v[2] & (a | r_v[1])));

    always_comb begin
        if (i_cmd.reset_state) begin
            n_cnt = '0;
        end else if (i_count_en) begin
            n_cnt = r_cnt + (i_last ? {60'd0, vb_sat} : 64'd8);
        end else begin
            n_cnt = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rnd <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= sha512t_pkg::IV[i];
        end else begin
            r_cnt <= n_cnt;
            if (i_cmd.start_comp) begin
                r_rnd <= '0;
            end else if (i_cmd.round_step) begin
                r_rnd <= r_rnd + 1'b1;
            end
            if (i_cmd.reset_state) begin
                for (int i = 0; i < 8; i++) r_h[i] <= sha512t_pkg::IV[i];
            end else if (i_cmd.finish_comp) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
            end
        end
    end

    // block buffer shifts in from the top; after 16 loads r_w[0] is the first word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_word) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= wr_word;
        end else if (i_cmd.round_step) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= sched_new;
        end
        if (i_cmd.start_comp) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
        end else if (i_cmd.round_step) begin
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4]; r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0]; r_v[0] <= t1 + t2;
        end
    end

    // chaining state holds still while the digest waits
    assign o_digest = {r_h[3], r_h[2], r_h[1], r_h[0]};
endmodule
`default_nettype wire

@@ rtl/core/sha512t_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sha512t_ctrl (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    input  wire                         i_last,
    input  wire [3:0]                   i_vb,
    output logic                        o_in_ready,
    output logic                        o_count_en,
    output logic                        o_out_valid,
    input  wire                         i_out_ready,
    output sha512t_pkg::t_dp_cmd        o_cmd
);
    localparam logic [2:0] StIdle  = 3'd0;
    localparam logic [2:0] StFill  = 3'd1; // 0x80 word, zero fill, length word
    localparam logic [2:0] StComp  = 3'd2;
    localparam logic [2:0] StOut   = 3'd3;

    logic [2:0] r_st, n_st;
    logic [3:0] r_nw, n_nw;        // words in block, 0..15
    logic [6:0] r_rc, n_rc;        // rounds left; 0 is the add-back cycle
    logic       r_tail, n_tail;    // message closed, padding in progress
    logic       r_padw, n_padw;    // separate 0x80 word still owed
    logic       r_fin, n_fin;      // length goes into the current block
    logic       accept;

    assign o_in_ready  = (r_st == StIdle);
    assign accept      = i_in_valid && o_in_ready;
    assign o_count_en  = accept;
    assign o_out_valid = (r_st == StOut);

    always_comb begin
        o_cmd = '0;
        n_st = r_st; n_nw = r_nw; n_rc = r_rc;
        n_tail = r_tail; n_padw = r_padw; n_fin = r_fin;
        unique case (r_st)
            StIdle: begin
                if (accept) begin
                    o_cmd.load_word = 1'b1;
                    o_cmd.word_sel = sha512t_pkg::SelMsg;
                    n_nw = r_nw + 4'd1;
                    if (i_last) begin
                        n_tail = 1'b1;
                        n_st = StFill;
                        if (i_vb >= 4'd8) begin
                            n_padw = 1'b1;
                        end else begin
                            // marker sits in this word; length fits if words 14, 15 are free
                            n_fin = (r_nw <= 4'd13);
                        end
                    end
                    if (r_nw == 4'd15) begin
                        o_cmd.start_comp = 1'b1;
                        n_rc = 7'd80;
                        n_st = StComp;
                    end
                end
            end
            StFill: begin
                o_cmd.load_word = 1'b1;
                n_nw = r_nw + 4'd1;
                if (r_padw) begin
                    o_cmd.word_sel = sha512t_pkg::SelPad;
                    n_padw = 1'b0;
                    n_fin = (r_nw <= 4'd13);
                end else if (r_nw == 4'd15 && r_fin) begin
                    o_cmd.word_sel = sha512t_pkg::SelLen;
                end else begin
                    o_cmd.word_sel = sha512t_pkg::SelZero;
                end
                if (r_nw == 4'd15) begin
                    o_cmd.start_comp = 1'b1;
                    n_rc = 7'd80;
                    n_st = StComp;
                end
            end
            StComp: begin
                if (r_rc != 7'd0) begin
                    o_cmd.round_step = 1'b1;
                    n_rc = r_rc - 7'd1;
                end else begin
                    o_cmd.finish_comp = 1'b1;
                    if (r_fin) begin
                        n_st = StOut;
                    end else if (r_tail) begin
                        // length did not fit: it goes into the next block
                        n_st = StFill;
                        n_fin = 1'b1;
                    end else begin
                        n_st = StIdle;
                    end
                end
            end
            StOut: begin
                if (i_out_ready) begin
                    o_cmd.reset_state = 1'b1;
                    n_st = StIdle; n_tail = 1'b0; n_fin = 1'b0;
                end
            end
            default: n_st = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= StIdle; r_nw <= '0; r_rc <= '0;
            r_tail <= 1'b0; r_padw <= 1'b0; r_fin <= 1'b0;
        end else begin
            r_st <= n_st; r_nw <= n_nw; r_rc <= n_rc;
            r_tail <= n_tail; r_padw <= n_padw; r_fin <= n_fin;
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/sha512_256_message_hash.sv @@
// Throughput: one input transaction per cycle while a block fills; a full block
// then holds the input through its 80 rounds and the add-back.
// After the last word, the digest waits on the fill words left in the block and
// on a second compression when the padding needs one.
// Reset (synchronous, active low) restores the initial chaining state and counts.
`timescale 1ns / 1ps
`default_nettype none
module sha512_256_message_hash (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [71:0]  s_axis_tdata,   // message_word[63:0], valid_bytes[67:64], zero pad
    input  wire          s_axis_tlast,   // last_word
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [255:0] m_axis_tdata    // digest_0, digest_1, digest_2, digest_3
);
    sha512t_pkg::t_dp_cmd cmd;
    logic count_en;
    logic [255:0] dig;

    sha512t_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid), .i_last(s_axis_tlast), .i_vb(s_axis_tdata[67:64]),
        .o_in_ready(s_axis_tready), .o_count_en(count_en),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready), .o_cmd(cmd)
    );

    sha512t_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd),
        .i_word(s_axis_tdata[63:0]), .i_vb(s_axis_tdata[67:64]), .i_last(s_axis_tlast),
        .i_count_en(count_en), .o_digest(dig)
    );

    assign m_axis_tdata = dig;
endmodule
`default_nettype wire

@@ rtl/core/sha512t_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sha512t_checker (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         s_axis_tready,
    input wire         m_axis_tvalid,
    input wire         m_axis_tready,
    input wire [255:0] m_axis_tdata
);
    `ASSERT_IMPLY(a_no_in_while_out, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready, "input open")
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "digest dropped")
    `ASSERT_NEXT(a_out_done, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready, !m_axis_tvalid, "digest repeated")
endmodule

bind sha512_256_message_hash sha512t_checker u_chk (
    .i_clk, .i_rst_n, .s_axis_tready,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
`default_nettype wire
